>>> hdl/vfap_pkg.sv
// Shared types and constants for the voice frame admission policer.
package vfap_pkg;

  localparam int ID_W      = 6;
  localparam int ID_COUNT  = 2 ** ID_W;
  localparam int TIME_W    = 32;
  localparam int COUNT_W   = 11;
  localparam int PAYLOAD_W = 12;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAMES   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHAN_HOLD    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_WINDOW = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD  = 3'd4;

  // Register reset values
  localparam logic [9:0]  RST_MAX_FRAMES   = 10'd100;
  localparam logic [15:0] RST_WINDOW       = 16'd1000;
  localparam logic [15:0] RST_CHAN_HOLD    = 16'd300;
  localparam logic [15:0] RST_NOISE_WINDOW = 16'd250;
  localparam logic [11:0] RST_MAX_PAYLOAD  = 12'd1275;

  typedef enum logic [2:0] {
    V_ADMIT   = 3'd0,
    V_UNKNOWN = 3'd1,
    V_DEAD    = 3'd2,
    V_RATE    = 3'd3,
    V_PAYLOAD = 3'd4,
    V_NOPAWN  = 3'd5
  } verdict_t;

  typedef enum logic [1:0] {
    R_NONE    = 2'd0,
    R_NORADIO = 2'd1,
    R_BUSY    = 2'd2,
    R_GRANT   = 2'd3
  } radio_t;

  typedef struct packed {
    logic [9:0]  max_frames;
    logic [15:0] window_ticks;
    logic [15:0] chan_hold_ticks;
    logic [15:0] noise_window_ticks;
    logic [11:0] max_payload;
  } cfg_t;

  // Classified frame as it waits in the queue
  typedef struct packed {
    logic [ID_W-1:0]   speaker_id;
    logic [TIME_W-1:0] now_ticks;
    verdict_t          early_verdict;
    logic              payload_bad;
    logic              no_pawn;
    logic              wants_radio;
    logic              usable_radio;
  } item_t;

  // Per-speaker rate and noise bookkeeping row
  typedef struct packed {
    logic [TIME_W-1:0]  window_start;
    logic [COUNT_W-1:0] frame_count;
    logic               noise_seen;
  } stat_t;

endpackage

>>> hdl/vfap_ram.sv
// Generic single-write, single-read RAM with registered read data.
module vfap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/vfap_front.sv
// Front end: accept frames, run the stateless checks, queue them for the back end.
module vfap_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  vfap_pkg::cfg_t                  cfg,
  input  logic                            hold_off,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [vfap_pkg::ID_W-1:0]       in_speaker_id,
  input  logic [vfap_pkg::TIME_W-1:0]     in_now_ticks,
  input  logic                            in_sender_known,
  input  logic                            in_speaker_dead,
  input  logic [vfap_pkg::PAYLOAD_W-1:0]  in_payload_bytes,
  input  logic                            in_has_pawn,
  input  logic                            in_wants_radio,
  input  logic                            in_has_usable_radio,
  output logic                            q_valid,
  output vfap_pkg::item_t                 q_item,
  input  logic                            q_pop
);
  import vfap_pkg::*;

  item_t       cls_item;
  item_t       q_mem_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  q_cnt_r, q_cnt_nxt;
  logic        push;

  // Classify: sender checks decide early, payload and pawn are flagged
  always_comb begin
    cls_item.speaker_id   = in_speaker_id;
    cls_item.now_ticks    = in_now_ticks;
    cls_item.payload_bad  = (in_payload_bytes == '0) || (in_payload_bytes > cfg.max_payload);
    cls_item.no_pawn      = !in_has_pawn;
    cls_item.wants_radio  = in_wants_radio;
    cls_item.usable_radio = in_has_usable_radio;
    if (!in_sender_known) begin
      cls_item.early_verdict = V_UNKNOWN;
    end else if (in_speaker_dead) begin
      cls_item.early_verdict = V_DEAD;
    end else begin
      cls_item.early_verdict = V_ADMIT;
    end
  end

  assign in_ready = (q_cnt_r != 2'd2) && !hold_off;
  assign push     = in_valid && in_ready;
  assign q_valid  = (q_cnt_r != 2'd0);
  assign q_item   = q_mem_r[rd_ptr_r];

  // Advance queue pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ q_pop;
    q_cnt_nxt  = q_cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      q_cnt_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      q_cnt_r  <= q_cnt_nxt;
    end
  end

  // Store the classified item
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cls_item;
    end
  end

endmodule

>>> hdl/vfap_back.sv
// Back end: per-speaker rate window, radio channel, noise throttle and result register.
module vfap_back #(
  parameter int SPEAKERS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  vfap_pkg::cfg_t        cfg,
  input  logic                  q_valid,
  input  vfap_pkg::item_t       q_item,
  output logic                  q_pop,
  output logic                  clearing,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            out_verdict,
  output logic [1:0]            out_radio_status,
  output logic                  out_report_noise,
  output logic                  out_noise_on_radio
);
  import vfap_pkg::*;

  localparam int SW = $clog2(SPEAKERS);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_RATE  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic [SW-1:0]      clr_idx_r, clr_idx_nxt;
  logic [SW-1:0]      slot_lut [ID_COUNT];
  logic [SW-1:0]      slot_r;
  item_t              cur_r;

  stat_t              stat_rd, stat_wr;
  logic [TIME_W-1:0]  noise_rd;
  logic               stat_we, noise_we, rd_en;
  logic [SW-1:0]      stat_waddr;

  logic [TIME_W-1:0]  win_diff, noise_diff, chan_diff;
  logic               new_win;
  logic [COUNT_W-1:0] cnt_base, cnt_inc;
  logic [TIME_W-1:0]  start_n_r;
  logic [COUNT_W-1:0] cnt_n_r;
  logic               seen_r, noise_hold_r;

  logic               chan_owned_r;
  logic [ID_W-1:0]    chan_owner_r;
  logic [TIME_W-1:0]  chan_last_r;

  verdict_t           verdict_c;
  radio_t             radio_c;
  logic               admitted, chan_free, noise_fire, done_go, out_free;

  logic               out_valid_r;
  verdict_t           out_verdict_r;
  radio_t             out_radio_r;
  logic               out_noise_r, out_on_radio_r;

  // Speaker id to slot, worked out at elaboration
  for (genvar g = 0; g < ID_COUNT; g++) begin : g_slot
    assign slot_lut[g] = SW'(g % SPEAKERS);
  end

  assign clearing = (state_r == S_CLEAR);
  assign out_free = !out_valid_r || out_ready;
  assign done_go  = (state_r == S_DONE) && out_free;
  assign rd_en    = (state_r == S_IDLE) && q_valid;
  assign q_pop    = rd_en;

  // Sequencer: clear the stat memory, then read, evaluate, write back
  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    unique case (state_r)
      S_CLEAR: begin
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == SW'(SPEAKERS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          state_nxt = S_RATE;
        end
      end
      S_RATE: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_idx_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
    end
  end

  // Latch the item being worked on
  always_ff @(posedge clk) begin
    if (rd_en) begin
      cur_r  <= q_item;
      slot_r <= slot_lut[q_item.speaker_id];
    end
  end

  // Rate window and noise gap from the row just read
  always_comb begin
    win_diff   = cur_r.now_ticks - stat_rd.window_start;
    new_win    = (win_diff >= {16'b0, cfg.window_ticks});
    cnt_base   = new_win ? '0 : stat_rd.frame_count;
    cnt_inc    = (cnt_base == COUNT_MAX) ? cnt_base : cnt_base + 1'b1;
    noise_diff = cur_r.now_ticks - noise_rd;
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RATE) begin
      start_n_r    <= new_win ? cur_r.now_ticks : stat_rd.window_start;
      cnt_n_r      <= cnt_inc;
      seen_r       <= stat_rd.noise_seen;
      noise_hold_r <= stat_rd.noise_seen && (noise_diff < {16'b0, cfg.noise_window_ticks});
    end
  end

  // Final verdict, radio channel and noise decision
  always_comb begin
    chan_diff = cur_r.now_ticks - chan_last_r;
    chan_free = !chan_owned_r || (chan_owner_r == cur_r.speaker_id) ||
                (chan_diff > {16'b0, cfg.chan_hold_ticks});
    priority if (cur_r.early_verdict != V_ADMIT) begin
      verdict_c = cur_r.early_verdict;
    end else if (cnt_n_r > {1'b0, cfg.max_frames}) begin
      verdict_c = V_RATE;
    end else if (cur_r.payload_bad) begin
      verdict_c = V_PAYLOAD;
    end else if (cur_r.no_pawn) begin
      verdict_c = V_NOPAWN;
    end else begin
      verdict_c = V_ADMIT;
    end
    admitted = (verdict_c == V_ADMIT);
    priority if (!admitted || !cur_r.wants_radio) begin
      radio_c = R_NONE;
    end else if (!cur_r.usable_radio) begin
      radio_c = R_NORADIO;
    end else if (!chan_free) begin
      radio_c = R_BUSY;
    end else begin
      radio_c = R_GRANT;
    end
    noise_fire = admitted && !noise_hold_r;
  end

  // Memory writes: clearing sweep or write-back of a counted frame
  always_comb begin
    stat_we    = clearing || (done_go && (cur_r.early_verdict == V_ADMIT));
    stat_waddr = clearing ? clr_idx_r : slot_r;
    if (clearing) begin
      stat_wr = '0;
    end else begin
      stat_wr.window_start = start_n_r;
      stat_wr.frame_count  = cnt_n_r;
      stat_wr.noise_seen   = seen_r || noise_fire;
    end
    noise_we = done_go && noise_fire;
  end

  vfap_ram #(
    .WIDTH ($bits(stat_t)),
    .DEPTH (SPEAKERS)
  ) u_stat_ram (
    .clk   (clk),
    .we    (stat_we),
    .waddr (stat_waddr),
    .wdata (stat_wr),
    .re    (rd_en),
    .raddr (slot_lut[q_item.speaker_id]),
    .rdata (stat_rd)
  );

  vfap_ram #(
    .WIDTH (TIME_W),
    .DEPTH (SPEAKERS)
  ) u_noise_ram (
    .clk   (clk),
    .we    (noise_we),
    .waddr (slot_r),
    .wdata (cur_r.now_ticks),
    .re    (rd_en),
    .raddr (slot_lut[q_item.speaker_id]),
    .rdata (noise_rd)
  );

  // Half-duplex channel ownership
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_owned_r <= 1'b0;
      chan_owner_r <= '0;
      chan_last_r  <= '0;
    end else if (done_go && (radio_c == R_GRANT)) begin
      chan_owned_r <= 1'b1;
      chan_owner_r <= cur_r.speaker_id;
      chan_last_r  <= cur_r.now_ticks;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_go) begin
      out_verdict_r  <= verdict_c;
      out_radio_r    <= radio_c;
      out_noise_r    <= noise_fire;
      out_on_radio_r <= noise_fire && (radio_c == R_GRANT);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_verdict        = out_verdict_r;
  assign out_radio_status   = out_radio_r;
  assign out_report_noise   = out_noise_r;
  assign out_noise_on_radio = out_on_radio_r;

  a_stat_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    stat_we |-> (state_r == S_CLEAR || state_r == S_DONE))
    else $error("stat memory written outside clear or write-back");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised without a finished item");

  a_grant_owner: assert property (@(posedge clk) disable iff (!rst_n)
    (done_go && radio_c == R_GRANT) |=>
      (chan_owned_r && chan_owner_r == $past(cur_r.speaker_id)))
    else $error("granted channel not owned by the speaker");

  a_reject_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_verdict_r != V_ADMIT) |->
      (out_radio_r == R_NONE && !out_noise_r && !out_on_radio_r))
    else $error("rejected frame carries radio or noise result");

  a_radio_tag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_on_radio_r) |-> (out_noise_r && out_radio_r == R_GRANT))
    else $error("radio noise tag without report or grant");

endmodule

>>> hdl/voice_frame_admission_policer_unit.sv
// Top level of the voice frame admission policer: register file, front end and back end.
//
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid/in_ready   | speaker_id, now_ticks, flags, payload_bytes
//  out_    | output    | out_valid/out_ready | verdict, radio_status, report_noise,
//          |           |                     | noise_on_radio
//  cfg_    | input     | cfg_we              | cfg_index, cfg_data
//
//  The front end takes one item per cycle into a two-entry queue while in_ready is high.
//  The back end works each item through stat read, window update and write-back,
//  set by the read-modify-write of the per-speaker stat memory, and takes no new item
//  until the write-back of the last one is done.
//  After reset the stat memory is swept to zero, with in_ready low.
//  A held result parks the back end at write-back; the front end keeps accepting
//  until its two-entry queue is full, then in_ready drops.
module voice_frame_admission_policer_unit #(
  parameter int SPEAKERS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [vfap_pkg::ID_W-1:0]         in_speaker_id,
  input  logic [vfap_pkg::TIME_W-1:0]       in_now_ticks,
  input  logic                              in_sender_known,
  input  logic                              in_speaker_dead,
  input  logic [vfap_pkg::PAYLOAD_W-1:0]    in_payload_bytes,
  input  logic                              in_has_pawn,
  input  logic                              in_wants_radio,
  input  logic                              in_has_usable_radio,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [2:0]                        out_verdict,
  output logic [1:0]                        out_radio_status,
  output logic                              out_report_noise,
  output logic                              out_noise_on_radio,
  input  logic                              cfg_we,
  input  logic [vfap_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vfap_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import vfap_pkg::*;

  cfg_t   cfg_r, cfg_nxt;
  logic   q_valid, q_pop, clearing;
  item_t  q_item;

  // Register file: low bits of the written data, unknown indexes dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_FRAMES:   cfg_nxt.max_frames         = cfg_data[9:0];
        REG_WINDOW:       cfg_nxt.window_ticks       = cfg_data;
        REG_CHAN_HOLD:    cfg_nxt.chan_hold_ticks    = cfg_data;
        REG_NOISE_WINDOW: cfg_nxt.noise_window_ticks = cfg_data;
        REG_MAX_PAYLOAD:  cfg_nxt.max_payload        = cfg_data[11:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_frames         <= RST_MAX_FRAMES;
      cfg_r.window_ticks       <= RST_WINDOW;
      cfg_r.chan_hold_ticks    <= RST_CHAN_HOLD;
      cfg_r.noise_window_ticks <= RST_NOISE_WINDOW;
      cfg_r.max_payload        <= RST_MAX_PAYLOAD;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  vfap_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg_r),
    .hold_off            (clearing),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_speaker_id       (in_speaker_id),
    .in_now_ticks        (in_now_ticks),
    .in_sender_known     (in_sender_known),
    .in_speaker_dead     (in_speaker_dead),
    .in_payload_bytes    (in_payload_bytes),
    .in_has_pawn         (in_has_pawn),
    .in_wants_radio      (in_wants_radio),
    .in_has_usable_radio (in_has_usable_radio),
    .q_valid             (q_valid),
    .q_item              (q_item),
    .q_pop               (q_pop)
  );

  vfap_back #(
    .SPEAKERS (SPEAKERS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .q_valid            (q_valid),
    .q_item             (q_item),
    .q_pop              (q_pop),
    .clearing           (clearing),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_verdict        (out_verdict),
    .out_radio_status   (out_radio_status),
    .out_report_noise   (out_report_noise),
    .out_noise_on_radio (out_noise_on_radio)
  );

endmodule

>>> tb/sv/voice_frame_admission_policer_unit_tb.sv
// Self-checking testbench for the voice frame admission policer with a built-in frame predictor.
module voice_frame_admission_policer_unit_tb;
  import vfap_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;  // no register behind this index
  localparam int STUCK_LIMIT = 3000;
  localparam int HOLD_OFF_CYCLES = 400;

  // One voice frame as driven on the in_ ports, in port order
  typedef struct packed {
    logic [ID_W-1:0]      speaker;
    logic [TIME_W-1:0]    now;
    logic                 known;
    logic                 dead;
    logic [PAYLOAD_W-1:0] payload;
    logic                 pawn;
    logic                 radio_req;
    logic                 usable;
  } frame_t;

  // One admission decision as seen on the out_ ports
  typedef struct packed {
    verdict_t verdict;
    radio_t   radio;
    logic     noise;
    logic     noise_radio;
  } outcome_t;

  typedef struct packed {
    logic     fixed;
    outcome_t o;
  } pin_t;

  typedef struct {
    bit       retune;
    frame_t   f;
    bit       fixed;
    outcome_t o;
  } row_t;

  typedef struct {
    int max_frames, window, hold, noise_gap, payload_cap;
    int tx_pct, rx_pct;
    int frames, span, tstep;
    bit jumps, burst, hold_off, pause;
  } phase_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [ID_W-1:0]      in_speaker_id = '0;
  logic [TIME_W-1:0]    in_now_ticks = '0;
  logic                 in_sender_known = 1'b0;
  logic                 in_speaker_dead = 1'b0;
  logic [PAYLOAD_W-1:0] in_payload_bytes = '0;
  logic                 in_has_pawn = 1'b0;
  logic                 in_wants_radio = 1'b0;
  logic                 in_has_usable_radio = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [2:0]           out_verdict;
  logic [1:0]           out_radio_status;
  logic                 out_report_noise;
  logic                 out_noise_on_radio;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor copy of the registers and per-speaker state
  logic [9:0]         lim_frames;
  logic [15:0]        lim_window, hold_ticks, noise_gap;
  logic [11:0]        payload_cap;
  logic [TIME_W-1:0]  win_start [ID_COUNT];
  logic [COUNT_W-1:0] frame_cnt [ID_COUNT];
  logic               noise_seen [ID_COUNT];
  logic [TIME_W-1:0]  noise_time [ID_COUNT];
  logic               chan_owned;
  logic [ID_W-1:0]    chan_owner;
  logic [TIME_W-1:0]  chan_time;

  outcome_t verdicts_due [$];
  pin_t     pinned_q [$];

  int tx_idle_pct = 0, rx_stall_pct = 0;
  int rx_hold_left = 0;
  bit hold_tog = 1'b0, hold_seen = 1'b0;
  logic [TIME_W-1:0] t_now = 32'd500000;
  int n_frames = 0, n_checked = 0, n_errors = 0, n_settings = 1, stuck_cycles = 0;
  int n_admit = 0, n_rate = 0, n_grant = 0, n_noise = 0;

  row_t   plan [$];
  phase_t phases [8];
  phase_t tight;

  voice_frame_admission_policer_unit dut (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Work out the decision for one frame and advance the predictor state
  function automatic outcome_t police_frame(frame_t f);
    outcome_t r;
    logic [ID_W-1:0] s;
    logic [TIME_W-1:0] dt;
    r.verdict = V_ADMIT;
    r.radio = R_NONE;
    r.noise = 1'b0;
    r.noise_radio = 1'b0;
    s = f.speaker;  // 64 slots: the slot is the id itself
    if (!f.known) begin
      r.verdict = V_UNKNOWN;
    end else if (f.dead) begin
      r.verdict = V_DEAD;
    end else begin
      // open a new window once the old one has run out, then count the frame
      dt = f.now - win_start[s];
      if (dt >= 32'(lim_window)) begin
        win_start[s] = f.now;
        frame_cnt[s] = '0;
      end
      if (frame_cnt[s] != COUNT_MAX) frame_cnt[s] = frame_cnt[s] + 1'b1;
      if (frame_cnt[s] > 11'(lim_frames)) begin
        r.verdict = V_RATE;
      end else if (f.payload == '0 || f.payload > payload_cap) begin
        r.verdict = V_PAYLOAD;
      end else if (!f.pawn) begin
        r.verdict = V_NOPAWN;
      end else begin
        if (f.radio_req) begin
          dt = f.now - chan_time;
          if (!f.usable) begin
            r.radio = R_NORADIO;
          end else if (chan_owned && chan_owner != f.speaker && dt <= 32'(hold_ticks)) begin
            r.radio = R_BUSY;
          end else begin
            r.radio = R_GRANT;
            chan_owned = 1'b1;
            chan_owner = f.speaker;
            chan_time = f.now;
          end
        end
        // throttle the noise report per speaker
        dt = f.now - noise_time[s];
        if (!(noise_seen[s] && dt < 32'(noise_gap))) begin
          noise_seen[s] = 1'b1;
          noise_time[s] = f.now;
          r.noise = 1'b1;
          r.noise_radio = (r.radio == R_GRANT);
        end
      end
    end
    return r;
  endfunction

  function automatic frame_t mk(int id, logic [31:0] t, bit kn, bit dd, int pay, bit pw,
                                bit rr, bit us);
    frame_t f;
    f.speaker = 6'(id);
    f.now = t;
    f.known = kn;
    f.dead = dd;
    f.payload = 12'(pay);
    f.pawn = pw;
    f.radio_req = rr;
    f.usable = us;
    return f;
  endfunction

  function automatic outcome_t res(verdict_t v, radio_t r, logic n, logic nr);
    outcome_t o;
    o.verdict = v;
    o.radio = r;
    o.noise = n;
    o.noise_radio = nr;
    return o;
  endfunction

  // Draw a frame: mostly well-formed from a few speakers, the rest noise
  function automatic frame_t next_frame(phase_t ph);
    frame_t f;
    int pick;
    pick = $urandom_range(0, 99);
    if (ph.jumps && pick >= 98) t_now = $urandom;
    else if (ph.jumps && pick >= 92) t_now += $urandom_range(0, 70000);
    else if (ph.jumps && pick >= 70) t_now += $urandom_range(0, ph.tstep * 10);
    else t_now += $urandom_range(0, ph.tstep);
    f.now = t_now;
    f.speaker = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, ph.span - 1));
    f.radio_req = 1'($urandom);
    f.usable = ($urandom_range(0, 6) != 0);
    if ($urandom_range(0, 4) != 0) begin
      f.known = 1'b1;
      f.dead = 1'b0;
      f.pawn = 1'b1;
      f.payload = (ph.payload_cap == 0) ? 12'($urandom) : 12'($urandom_range(1, ph.payload_cap));
    end else begin
      f.known = 1'($urandom);
      f.dead = 1'($urandom);
      f.pawn = 1'($urandom);
      pick = $urandom_range(0, 3);
      f.payload = (pick == 0) ? 12'd0 : (pick == 1) ? 12'hFFF : 12'($urandom);
    end
    if (ph.burst) begin
      f.speaker = 6'd9;
      f.known = 1'b1;
      f.dead = 1'b0;
    end
    return f;
  endfunction

  // Offer one item, holding it until accepted
  task automatic send_frame(frame_t f, bit fixed, outcome_t o);
    pin_t p;
    while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    p.fixed = fixed;
    p.o = o;
    pinned_q.push_back(p);
    in_valid <= 1'b1;
    {in_speaker_id, in_now_ticks, in_sender_known, in_speaker_dead, in_payload_bytes,
     in_has_pawn, in_wants_radio, in_has_usable_radio} <= f;
    do @(posedge clk); while (in_ready !== 1'b1);
    @(negedge clk);
  endtask

  // Stop offering and wait until every result is back
  task automatic quiesce();
    in_valid <= 1'b0;
    @(negedge clk);
    while (verdicts_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val, logic [15:0] used);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= (val & used) | (16'($urandom) & ~used);
    @(negedge clk);
  endtask

  // Write all registers; unused upper bits carry junk
  task automatic load_regs(phase_t ph, bit poke_spare);
    write_reg(REG_MAX_FRAMES, 16'(ph.max_frames), 16'h03FF);
    write_reg(REG_WINDOW, 16'(ph.window), 16'hFFFF);
    write_reg(REG_CHAN_HOLD, 16'(ph.hold), 16'hFFFF);
    write_reg(REG_NOISE_WINDOW, 16'(ph.noise_gap), 16'hFFFF);
    write_reg(REG_MAX_PAYLOAD, 16'(ph.payload_cap), 16'h0FFF);
    if (poke_spare) write_reg(REG_SPARE, 16'($urandom), 16'hFFFF);
    cfg_we <= 1'b0;
    @(negedge clk);
    n_settings++;
  endtask

  // Receiver: random stalls, plus a long hold-off when requested
  always @(negedge clk) begin
    if (hold_tog != hold_seen) begin
      hold_seen = hold_tog;
      rx_hold_left = HOLD_OFF_CYCLES;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= (rx_stall_pct == 0) || ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // Monitor: predict on accepted items, check accepted results, track registers
  always @(posedge clk) begin
    outcome_t got, want;
    pin_t pin;
    bit moved;
    moved = 1'b0;
    if (!rst_n) begin
      lim_frames = RST_MAX_FRAMES;
      lim_window = RST_WINDOW;
      hold_ticks = RST_CHAN_HOLD;
      noise_gap = RST_NOISE_WINDOW;
      payload_cap = RST_MAX_PAYLOAD;
      for (int i = 0; i < ID_COUNT; i++) begin
        win_start[i] = '0;
        frame_cnt[i] = '0;
        noise_seen[i] = 1'b0;
        noise_time[i] = '0;
      end
      chan_owned = 1'b0;
      chan_owner = '0;
      chan_time = '0;
    end else begin
      // check the result against the oldest expectation
      if (out_valid === 1'b1 && out_ready) begin
        moved = 1'b1;
        n_checked++;
        got = {out_verdict, out_radio_status, out_report_noise, out_noise_on_radio};
        if (verdicts_due.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("result %0d arrived with nothing expected: %0d %0d %0b %0b", n_checked,
                     out_verdict, out_radio_status, out_report_noise, out_noise_on_radio);
        end else begin
          want = verdicts_due.pop_front();
          if (got !== want) begin
            n_errors++;
            if (n_errors <= 10)
              $display("result %0d: expected verdict %0d radio %0d noise %0b on-radio %0b, %s",
                       n_checked, want.verdict, want.radio, want.noise, want.noise_radio,
                       $sformatf("got %0d %0d %0b %0b", out_verdict, out_radio_status,
                                 out_report_noise, out_noise_on_radio));
          end
        end
      end
      // predict the accepted item
      if (in_valid && in_ready === 1'b1) begin
        moved = 1'b1;
        n_frames++;
        pin = pinned_q.pop_front();
        want = police_frame({in_speaker_id, in_now_ticks, in_sender_known, in_speaker_dead,
                             in_payload_bytes, in_has_pawn, in_wants_radio,
                             in_has_usable_radio});
        if (pin.fixed) want = pin.o;
        verdicts_due.push_back(want);
        if (want.verdict == V_ADMIT) n_admit++;
        if (want.verdict == V_RATE) n_rate++;
        if (want.radio == R_GRANT) n_grant++;
        if (want.noise) n_noise++;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_MAX_FRAMES:   lim_frames = cfg_data[9:0];
          REG_WINDOW:       lim_window = cfg_data;
          REG_CHAN_HOLD:    hold_ticks = cfg_data;
          REG_NOISE_WINDOW: noise_gap = cfg_data;
          REG_MAX_PAYLOAD:  payload_cap = cfg_data[11:0];
          default: ;
        endcase
      end
      // watchdog on cycles with no handshake
      stuck_cycles = moved ? 0 : stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("no item moved for %0d cycles, %0d results outstanding", stuck_cycles,
                 verdicts_due.size());
        $display("[voice_frame_admission_policer_unit] ERROR");
        $finish;
      end
    end
  end

  initial begin
    // Directed rows on reset register values
    plan.push_back('{0, mk(0, 0, 0, 0, 0, 0, 0, 0), 1, res(V_UNKNOWN, R_NONE, 0, 0)});
    plan.push_back('{0, mk(63, 32'hFFFF_FFFF, 1, 1, 4095, 1, 1, 1), 1,
                     res(V_DEAD, R_NONE, 0, 0)});
    plan.push_back('{0, mk(1, 10, 1, 0, 0, 1, 1, 1), 1, res(V_PAYLOAD, R_NONE, 0, 0)});
    plan.push_back('{0, mk(1, 11, 1, 0, 4095, 1, 0, 0), 1, res(V_PAYLOAD, R_NONE, 0, 0)});
    plan.push_back('{0, mk(1, 12, 1, 0, 1275, 0, 1, 1), 1, res(V_NOPAWN, R_NONE, 0, 0)});
    plan.push_back('{0, mk(1, 13, 1, 0, 1, 1, 0, 0), 1, res(V_ADMIT, R_NONE, 1, 0)});
    plan.push_back('{0, mk(1, 14, 1, 0, 100, 1, 1, 0), 1, res(V_ADMIT, R_NORADIO, 0, 0)});
    plan.push_back('{0, mk(2, 20, 1, 0, 64, 1, 1, 1), 1, res(V_ADMIT, R_GRANT, 1, 1)});
    plan.push_back('{0, mk(3, 30, 1, 0, 64, 1, 1, 1), 1, res(V_ADMIT, R_BUSY, 1, 0)});
    plan.push_back('{0, mk(2, 40, 1, 0, 64, 1, 1, 1), 1, res(V_ADMIT, R_GRANT, 0, 0)});
    // channel frees once the hold time has passed; time wraps past zero
    plan.push_back('{0, mk(3, 341, 1, 0, 64, 1, 1, 1), 0, '0});
    plan.push_back('{0, mk(3, 341, 1, 0, 64, 1, 1, 1), 0, '0});
    plan.push_back('{0, mk(4, 32'hFFFF_FF00, 1, 0, 500, 1, 0, 1), 0, '0});
    plan.push_back('{0, mk(4, 32'h10, 1, 0, 500, 1, 1, 1), 0, '0});
    // Tight registers: one frame per window, longest window, zero hold and noise gap
    plan.push_back('{1, mk(6, 100000, 1, 0, 4095, 1, 0, 0), 1, res(V_ADMIT, R_NONE, 1, 0)});
    plan.push_back('{0, mk(6, 100001, 1, 0, 10, 1, 0, 0), 1, res(V_RATE, R_NONE, 0, 0)});
    plan.push_back('{0, mk(6, 100002, 0, 0, 10, 1, 0, 0), 1, res(V_UNKNOWN, R_NONE, 0, 0)});
    plan.push_back('{0, mk(6, 100003, 1, 1, 10, 1, 0, 0), 1, res(V_DEAD, R_NONE, 0, 0)});
    plan.push_back('{0, mk(6, 165535, 1, 0, 10, 1, 0, 0), 1, res(V_ADMIT, R_NONE, 1, 0)});
    plan.push_back('{0, mk(7, 342, 1, 0, 10, 1, 1, 1), 0, '0});
    plan.push_back('{0, mk(8, 342, 1, 0, 10, 1, 1, 1), 0, '0});
    plan.push_back('{0, mk(8, 343, 1, 0, 10, 1, 1, 1), 0, '0});
    tight = '{1, 65535, 0, 0, 4095, 0, 0, 0, 1, 1, 0, 0, 0, 0};

    // max, window, hold, noise, payload, tx%, rx%, frames, span, step, jumps, burst, hold, pause
    phases = '{
      '{3, 50, 20, 10, 200, 0, 0, 100, 8, 8, 1, 0, 0, 0},
      '{1023, 65535, 65535, 65535, 4095, 48, 0, 100, 64, 2000, 1, 0, 0, 0},
      '{1, 1, 0, 0, 1, 0, 48, 100, 4, 2, 1, 0, 0, 0},
      '{0, 0, 5, 3, 4095, 33, 33, 70, 8, 4, 1, 0, 0, 0},
      '{2, 0, 100, 40, 0, 0, 0, 70, 8, 20, 1, 0, 0, 0},
      '{5, 30, 10, 8, 1000, 33, 33, 110, 6, 6, 1, 0, 1, 0},
      '{100, 1000, 300, 250, 1275, 48, 48, 130, 16, 100, 1, 0, 0, 1},
      '{1023, 65535, 0, 65535, 4095, 0, 0, 1040, 1, 1, 0, 1, 0, 0}
    };

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Walk the directed rows
    foreach (plan[i]) begin
      if (plan[i].retune) begin
        quiesce();
        load_regs(tight, 1'b1);
      end
      send_frame(plan[i].f, plan[i].fixed, plan[i].o);
    end

    // Random phases, each under its own register setting and idle pattern
    foreach (phases[p]) begin
      quiesce();
      load_regs(phases[p], 1'b0);
      tx_idle_pct = phases[p].tx_pct;
      rx_stall_pct = phases[p].rx_pct;
      if (phases[p].hold_off) hold_tog = ~hold_tog;
      if (phases[p].burst) t_now += 70000;  // start the burst in a fresh window
      for (int k = 0; k < phases[p].frames; k++) begin
        if (phases[p].pause && k == phases[p].frames / 2) quiesce();
        send_frame(next_frame(phases[p]), 1'b0, '0);
      end
    end

    quiesce();
    $display("ran %0d frames under %0d register settings, %0d results checked",
             n_frames, n_settings, n_checked);
    $display("admitted %0d, rate limited %0d, radio grants %0d, noise reports %0d",
             n_admit, n_rate, n_grant, n_noise);
    if (n_errors == 0) begin
      $display("[voice_frame_admission_policer_unit] OK");
    end else begin
      $display("%0d results did not match", n_errors);
      $display("[voice_frame_admission_policer_unit] ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/vfap_pkg.sv
hdl/vfap_ram.sv
hdl/vfap_front.sv
hdl/vfap_back.sv
hdl/voice_frame_admission_policer_unit.sv
tb/sv/voice_frame_admission_policer_unit_tb.sv
